[src/asc_pkg.sv]
// asc_pkg: shared widths, constants, microcode field codes and control structs
// for the audio sync sample compensator; no dependencies
`timescale 1ns / 1ps

package asc_pkg;

    // field and register widths
    localparam int N_W       = 16;
    localparam int D_W       = 32;
    localparam int OUT_W     = 17;
    localparam int COEF_W    = 16;
    localparam int THR_W     = 31;
    localparam int RATE_W    = 19;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 31;

    // datapath widths
    localparam int SUM_W  = 40;
    localparam int MUL_W  = 21;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 58;
    localparam int AVG_W  = 42;
    localparam int WANT_W = 38;
    localparam int NX_W   = 20;
    localparam int STEP_W = 4;

    localparam int AVG_COUNT_DEF = 20;

    // register reset values
    localparam logic [COEF_W-1:0] COEF_RST = 16'd52057;
    localparam logic [THR_W-1:0]  THR_RST  = 31'd1398;
    localparam logic [RATE_W-1:0] RATE_RST = 19'd48000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd2;

    // 10 s in q15.16
    localparam logic signed [D_W-1:0] NOSYNC_LIM = 32'sd655360;

    // ceil(2^23 / 10), exact floor(x/10) for x below 2^20
    localparam logic [NX_W-1:0] RECIP_10 = 20'hCCCCD;
    localparam int RECIP_SH = 23;

    // multiplier operand a
    typedef logic [2:0] t_asel;
    localparam t_asel A_SUM_LO = 3'd0;
    localparam t_asel A_SUM_HI = 3'd1;
    localparam t_asel A_D_LO   = 3'd2;
    localparam t_asel A_D_HI   = 3'd3;
    localparam t_asel A_N9     = 3'd4;
    localparam t_asel A_N11    = 3'd5;

    // multiplier operand b
    typedef logic [1:0] t_bsel;
    localparam t_bsel B_COEF  = 2'd0;
    localparam t_bsel B_ICOEF = 2'd1;
    localparam t_bsel B_RATE  = 2'd2;
    localparam t_bsel B_RECIP = 2'd3;

    // accumulator op
    typedef logic [1:0] t_accop;
    localparam t_accop ACC_HOLD = 2'd0;
    localparam t_accop ACC_LOAD = 2'd1;
    localparam t_accop ACC_ADD  = 2'd2;

    // product alignment
    typedef logic [1:0] t_sh;
    localparam t_sh SH_0  = 2'd0;
    localparam t_sh SH_16 = 2'd1;
    localparam t_sh SH_20 = 2'd2;

    // register write
    typedef logic [2:0] t_wr;
    localparam t_wr WR_NONE  = 3'd0;
    localparam t_wr WR_SUM   = 3'd1;
    localparam t_wr WR_AVG   = 3'd2;
    localparam t_wr WR_WANT  = 3'd3;
    localparam t_wr WR_LO    = 3'd4;
    localparam t_wr WR_FINAL = 3'd5;
    localparam t_wr WR_PASS  = 3'd6;
    localparam t_wr WR_CLEAR = 3'd7;

    // jump condition
    typedef logic [2:0] t_cond;
    localparam t_cond C_NEVER   = 3'd0;
    localparam t_cond C_INVALID = 3'd1;
    localparam t_cond C_BIG     = 3'd2;
    localparam t_cond C_WARM    = 3'd3;
    localparam t_cond C_BELOW   = 3'd4;

    typedef logic [STEP_W-1:0] t_step;
    localparam t_step ST_PASS  = 4'd13;
    localparam t_step ST_CLEAR = 4'd14;

    typedef struct packed {
        t_asel  a_sel;
        t_bsel  b_sel;
        t_accop acc_op;
        t_sh    acc_sh;
        t_wr    wr;
        t_cond  cond;
        t_step  target;
        logic   last;
    } t_ctrl;

    typedef struct packed {
        logic invalid;
        logic big;
        logic warm;
        logic below;
    } t_flags;

endpackage

[src/asc_urom.sv]
// asc_urom: microcode program, one control word per step
// depends on asc_pkg
`timescale 1ns / 1ps

module asc_urom (
    input  asc_pkg::t_step i_step,
    output asc_pkg::t_ctrl o_ctrl
);

    always_comb begin
        o_ctrl = '0;
        case (i_step)
            // c * sum, low half first
            4'd0: begin
                o_ctrl.a_sel  = asc_pkg::A_SUM_LO;
                o_ctrl.b_sel  = asc_pkg::B_COEF;
                o_ctrl.cond   = asc_pkg::C_INVALID;
                o_ctrl.target = asc_pkg::ST_PASS;
            end
            4'd1: begin
                o_ctrl.a_sel  = asc_pkg::A_SUM_HI;
                o_ctrl.b_sel  = asc_pkg::B_COEF;
                o_ctrl.acc_op = asc_pkg::ACC_LOAD;
                o_ctrl.acc_sh = asc_pkg::SH_0;
                o_ctrl.cond   = asc_pkg::C_BIG;
                o_ctrl.target = asc_pkg::ST_CLEAR;
            end
            4'd2: begin
                o_ctrl.acc_op = asc_pkg::ACC_ADD;
                o_ctrl.acc_sh = asc_pkg::SH_20;
            end
            // new sum, warm-up counts here
            4'd3: begin
                o_ctrl.wr     = asc_pkg::WR_SUM;
                o_ctrl.cond   = asc_pkg::C_WARM;
                o_ctrl.target = asc_pkg::ST_PASS;
            end
            // (1 - c) * sum
            4'd4: begin
                o_ctrl.a_sel = asc_pkg::A_SUM_LO;
                o_ctrl.b_sel = asc_pkg::B_ICOEF;
            end
            4'd5: begin
                o_ctrl.a_sel  = asc_pkg::A_SUM_HI;
                o_ctrl.b_sel  = asc_pkg::B_ICOEF;
                o_ctrl.acc_op = asc_pkg::ACC_LOAD;
                o_ctrl.acc_sh = asc_pkg::SH_0;
            end
            4'd6: begin
                o_ctrl.acc_op = asc_pkg::ACC_ADD;
                o_ctrl.acc_sh = asc_pkg::SH_20;
            end
            // keep average, start d * rate
            4'd7: begin
                o_ctrl.wr    = asc_pkg::WR_AVG;
                o_ctrl.a_sel = asc_pkg::A_D_LO;
                o_ctrl.b_sel = asc_pkg::B_RATE;
            end
            4'd8: begin
                o_ctrl.a_sel  = asc_pkg::A_D_HI;
                o_ctrl.b_sel  = asc_pkg::B_RATE;
                o_ctrl.acc_op = asc_pkg::ACC_LOAD;
                o_ctrl.acc_sh = asc_pkg::SH_0;
                o_ctrl.cond   = asc_pkg::C_BELOW;
                o_ctrl.target = asc_pkg::ST_PASS;
            end
            4'd9: begin
                o_ctrl.a_sel  = asc_pkg::A_N9;
                o_ctrl.b_sel  = asc_pkg::B_RECIP;
                o_ctrl.acc_op = asc_pkg::ACC_ADD;
                o_ctrl.acc_sh = asc_pkg::SH_16;
            end
            // unclamped count, then the 90 and 110 percent bounds
            4'd10: begin
                o_ctrl.wr     = asc_pkg::WR_WANT;
                o_ctrl.a_sel  = asc_pkg::A_N11;
                o_ctrl.b_sel  = asc_pkg::B_RECIP;
                o_ctrl.acc_op = asc_pkg::ACC_LOAD;
                o_ctrl.acc_sh = asc_pkg::SH_0;
            end
            4'd11: begin
                o_ctrl.wr     = asc_pkg::WR_LO;
                o_ctrl.acc_op = asc_pkg::ACC_LOAD;
                o_ctrl.acc_sh = asc_pkg::SH_0;
            end
            4'd12: begin
                o_ctrl.wr   = asc_pkg::WR_FINAL;
                o_ctrl.last = 1'b1;
            end
            asc_pkg::ST_CLEAR: begin
                o_ctrl.wr   = asc_pkg::WR_CLEAR;
                o_ctrl.last = 1'b1;
            end
            default: begin
                o_ctrl.wr   = asc_pkg::WR_PASS;
                o_ctrl.last = 1'b1;
            end
        endcase
    end

endmodule

[src/asc_dpath.sv]
// asc_dpath: shared multiplier, accumulator, running sum, warm-up counter
// and result register; depends on asc_pkg
`timescale 1ns / 1ps

module asc_dpath #(
    parameter int AVG_COUNT = asc_pkg::AVG_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_en,
    input  asc_pkg::t_ctrl                i_ctrl,
    input  logic [asc_pkg::N_W-1:0]       i_frame_samples,
    input  logic signed [asc_pkg::D_W-1:0] i_clock_diff,
    input  logic                          i_diff_valid,
    input  logic [asc_pkg::COEF_W-1:0]    i_coef,
    input  logic [asc_pkg::THR_W-1:0]     i_thr,
    input  logic [asc_pkg::RATE_W-1:0]    i_rate,
    output asc_pkg::t_flags               o_flags,
    output logic [asc_pkg::OUT_W-1:0]     o_wanted_samples,
    output logic                          o_corrected
);

    localparam int WarmW = $clog2(AVG_COUNT + 1);
    localparam int ACC_W = asc_pkg::ACC_W;
    localparam int SUM_W = asc_pkg::SUM_W;
    localparam int MUL_W = asc_pkg::MUL_W;
    localparam int AVG_W = asc_pkg::AVG_W;
    localparam int WANT_W = asc_pkg::WANT_W;
    localparam int OUT_W = asc_pkg::OUT_W;
    localparam int COEF_W_P1 = asc_pkg::COEF_W + 1;

    logic [asc_pkg::N_W-1:0]        r_n;
    logic signed [asc_pkg::D_W-1:0] r_d;
    logic                           r_dv;
    logic signed [SUM_W-1:0]        r_sum;
    logic [WarmW-1:0]               r_warm;
    logic signed [asc_pkg::PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [AVG_W-1:0]        r_avg;
    logic signed [WANT_W-1:0]       r_want;
    logic [OUT_W-1:0]               r_lo;
    logic [OUT_W-1:0]               r_wanted;
    logic                           r_corr;

    logic [asc_pkg::NX_W-1:0]  n9;
    logic [asc_pkg::NX_W-1:0]  n11;
    logic [COEF_W_P1-1:0]      icoef;
    logic signed [MUL_W-1:0]   op_a;
    logic signed [MUL_W-1:0]   op_b;
    logic signed [ACC_W-1:0]   prod_x;
    logic signed [ACC_W-1:0]   prod_sh;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [ACC_W-1:0]   acc_q;
    logic signed [ACC_W-1:0]   sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic [AVG_W-1:0]          avg_abs;
    logic [OUT_W-1:0]          hi;
    logic signed [WANT_W-1:0]  lo_s;
    logic signed [WANT_W-1:0]  hi_s;
    logic [OUT_W-1:0]          clamped;

    assign n9    = (asc_pkg::NX_W'(r_n) << 3) + asc_pkg::NX_W'(r_n);
    assign n11   = (asc_pkg::NX_W'(r_n) << 3) + (asc_pkg::NX_W'(r_n) << 1)
                   + asc_pkg::NX_W'(r_n);
    assign icoef = {1'b1, {asc_pkg::COEF_W{1'b0}}} - {1'b0, i_coef};

    // operand a
    always_comb begin
        case (i_ctrl.a_sel)
            asc_pkg::A_SUM_LO: op_a = $signed({1'b0, r_sum[19:0]});
            asc_pkg::A_SUM_HI: op_a = $signed({r_sum[SUM_W-1], r_sum[SUM_W-1:20]});
            asc_pkg::A_D_LO:   op_a = $signed({5'b0, r_d[15:0]});
            asc_pkg::A_D_HI:   op_a = $signed({{5{r_d[31]}}, r_d[31:16]});
            asc_pkg::A_N9:     op_a = $signed({1'b0, n9});
            asc_pkg::A_N11:    op_a = $signed({1'b0, n11});
            default:           op_a = '0;
        endcase
    end

    // operand b
    always_comb begin
        case (i_ctrl.b_sel)
            asc_pkg::B_COEF:  op_b = $signed({5'b0, i_coef});
            asc_pkg::B_ICOEF: op_b = $signed({4'b0, icoef});
            asc_pkg::B_RATE:  op_b = $signed({2'b0, i_rate});
            asc_pkg::B_RECIP: op_b = $signed({1'b0, asc_pkg::RECIP_10});
            default:          op_b = '0;
        endcase
    end

    assign prod_x = ACC_W'(r_prod);

    always_comb begin
        case (i_ctrl.acc_sh)
            asc_pkg::SH_16: prod_sh = prod_x <<< 16;
            asc_pkg::SH_20: prod_sh = prod_x <<< 20;
            default:        prod_sh = prod_x;
        endcase
    end

    // divide by 2^16, truncating toward zero
    assign acc_rnd = r_acc + (r_acc[ACC_W-1] ? ACC_W'(17'h0FFFF) : '0);
    assign acc_q   = acc_rnd >>> 16;

    assign sum_wide = acc_q + ACC_W'(r_d);

    always_comb begin
        if (sum_wide[ACC_W-1:SUM_W-1] == '0 || sum_wide[ACC_W-1:SUM_W-1] == '1) begin
            sum_sat = sum_wide[SUM_W-1:0];
        end else if (sum_wide[ACC_W-1]) begin
            sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    assign avg_abs = r_avg[AVG_W-1] ? AVG_W'(-r_avg) : AVG_W'(r_avg);

    // clamp to 90..110 percent
    assign hi   = r_acc[asc_pkg::RECIP_SH +: OUT_W];
    assign lo_s = $signed({{(WANT_W-OUT_W){1'b0}}, r_lo});
    assign hi_s = $signed({{(WANT_W-OUT_W){1'b0}}, hi});

    always_comb begin
        if (r_want < lo_s) begin
            clamped = r_lo;
        end else if (r_want > hi_s) begin
            clamped = hi;
        end else begin
            clamped = r_want[OUT_W-1:0];
        end
    end

    assign o_flags.invalid = !r_dv;
    assign o_flags.big     = (r_d >= asc_pkg::NOSYNC_LIM) || (r_d <= -asc_pkg::NOSYNC_LIM);
    assign o_flags.warm    = r_warm < WarmW'(AVG_COUNT);
    assign o_flags.below   = avg_abs < AVG_W'(i_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_warm <= '0;
        end else if (i_en) begin
            case (i_ctrl.wr)
                asc_pkg::WR_SUM: begin
                    r_sum <= sum_sat;
                    if (r_warm < WarmW'(AVG_COUNT)) begin
                        r_warm <= r_warm + 1'b1;
                    end
                end
                asc_pkg::WR_CLEAR: begin
                    r_sum  <= '0;
                    r_warm <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_n  <= i_frame_samples;
            r_d  <= i_clock_diff;
            r_dv <= i_diff_valid;
        end
        if (i_en) begin
            r_prod <= op_a * op_b;
            case (i_ctrl.acc_op)
                asc_pkg::ACC_LOAD: r_acc <= prod_sh;
                asc_pkg::ACC_ADD:  r_acc <= r_acc + prod_sh;
                default: ;
            endcase
            case (i_ctrl.wr)
                asc_pkg::WR_AVG:  r_avg  <= acc_q[AVG_W-1:0];
                asc_pkg::WR_WANT: r_want <= acc_q[WANT_W-1:0]
                                            + $signed({{(WANT_W-asc_pkg::N_W){1'b0}}, r_n});
                asc_pkg::WR_LO:   r_lo   <= r_acc[asc_pkg::RECIP_SH +: OUT_W];
                asc_pkg::WR_FINAL: begin
                    r_wanted <= clamped;
                    r_corr   <= 1'b1;
                end
                asc_pkg::WR_PASS, asc_pkg::WR_CLEAR: begin
                    r_wanted <= {1'b0, r_n};
                    r_corr   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_wanted_samples = r_wanted;
    assign o_corrected      = r_corr;

endmodule

[src/audio_sync_sample_compensator_top.sv]
// audio_sync_sample_compensator_top: step counter, handshakes and register file
// around the microcode rom and datapath; depends on asc_pkg, asc_urom, asc_dpath
`timescale 1ns / 1ps

// usage
// - input channel: i_valid / o_stall, one word per decoded audio frame carrying
//   the frame's sample count, the clock difference (signed q15.16 s) and its
//   valid flag; a word is taken when i_valid is high and o_stall is low
// - output channel: o_valid / i_stall, one word per input word with the wanted
//   sample count and a flag that marks a corrected count
// - register port: i_cfg_valid / o_cfg_ready with an index (0 coefficient,
//   1 threshold, 2 source rate) and data; writes are taken while no frame is
//   in progress
// - sequencing: the microcode program ends early for a frame whose difference
//   is invalid, a large jump, a warm-up frame or a frame under threshold, in
//   that order along the program, and runs to the end for a corrected frame;
//   no new word is taken until the result register is written; the program
//   runs on the single shared 21x21 multiplier
// - the result register frees the sequencer: a new frame runs while the last
//   result waits; if the receiver stalls, the last step of the next frame
//   holds until the register is taken
// - reset clears the running sum, the warm-up counter and the handshakes and
//   loads the register defaults
module audio_sync_sample_compensator_top #(
    parameter int AVG_COUNT = asc_pkg::AVG_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input words
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [asc_pkg::N_W-1:0]            i_frame_samples,
    input  logic signed [asc_pkg::D_W-1:0]     i_clock_diff,
    input  logic                               i_diff_valid,
    // result words
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [asc_pkg::OUT_W-1:0]          o_wanted_samples,
    output logic                               o_corrected,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [asc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [asc_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    logic                          r_busy;
    asc_pkg::t_step                r_step;
    logic                          r_out_valid;
    logic [asc_pkg::COEF_W-1:0]    r_coef;
    logic [asc_pkg::THR_W-1:0]     r_thr;
    logic [asc_pkg::RATE_W-1:0]    r_rate;

    asc_pkg::t_ctrl  ctrl;
    asc_pkg::t_flags flags;
    logic            accept;
    logic            en;
    logic            take;
    logic            hold;

    asc_urom u_urom (
        .i_step (r_step),
        .o_ctrl (ctrl)
    );

    asc_dpath #(
        .AVG_COUNT (AVG_COUNT)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (accept),
        .i_en             (en),
        .i_ctrl           (ctrl),
        .i_frame_samples  (i_frame_samples),
        .i_clock_diff     (i_clock_diff),
        .i_diff_valid     (i_diff_valid),
        .i_coef           (r_coef),
        .i_thr            (r_thr),
        .i_rate           (r_rate),
        .o_flags          (flags),
        .o_wanted_samples (o_wanted_samples),
        .o_corrected      (o_corrected)
    );

    assign o_stall     = r_busy;
    assign o_cfg_ready = !r_busy;
    assign o_valid     = r_out_valid;
    assign accept      = i_valid && !r_busy;

    // last step waits while the result register is still full and stalled
    assign hold = ctrl.last && r_out_valid && i_stall;
    assign en   = r_busy && !hold;

    // jump condition select
    always_comb begin
        case (ctrl.cond)
            asc_pkg::C_INVALID: take = flags.invalid;
            asc_pkg::C_BIG:     take = flags.big;
            asc_pkg::C_WARM:    take = flags.warm;
            asc_pkg::C_BELOW:   take = flags.below;
            default:            take = 1'b0;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (en) begin
                if (ctrl.last) begin
                    r_busy <= 1'b0;
                end else if (take) begin
                    r_step <= ctrl.target;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            if (en && ctrl.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= asc_pkg::COEF_RST;
            r_thr  <= asc_pkg::THR_RST;
            r_rate <= asc_pkg::RATE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                asc_pkg::REG_COEF: r_coef <= i_cfg_data[asc_pkg::COEF_W-1:0];
                asc_pkg::REG_THR:  r_thr  <= i_cfg_data[asc_pkg::THR_W-1:0];
                asc_pkg::REG_RATE: r_rate <= i_cfg_data[asc_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

[verif/audio_sync_sample_compensator_top_tb.sv]
// audio_sync_sample_compensator_top_tb: self-checking bench for the audio sync
// sample compensator; uses asc_pkg and the rtl under src, nothing else
`timescale 1ns / 1ps

typedef struct packed {
    logic [asc_pkg::OUT_W-1:0] wanted;
    logic                      corrected;
} t_frame_result;

// tracks the running clock-difference sum and predicts each frame's result
class compensator_scoreboard;
    logic [asc_pkg::COEF_W-1:0] coef;
    logic [asc_pkg::THR_W-1:0]  threshold;
    logic [asc_pkg::RATE_W-1:0] rate;
    longint                     diff_sum;
    int                         warmup_count;
    int                         avg_frames;
    t_frame_result              wanted_q[$];
    int frames, results, corrections, clamps, resyncs, unknown_diffs, mismatches;

    function new(int avg_count);
        coef          = asc_pkg::COEF_RST;
        threshold     = asc_pkg::THR_RST;
        rate          = asc_pkg::RATE_RST;
        diff_sum      = 0;
        warmup_count  = 0;
        avg_frames    = avg_count;
        frames        = 0;
        results       = 0;
        corrections   = 0;
        clamps        = 0;
        resyncs       = 0;
        unknown_diffs = 0;
        mismatches    = 0;
    endfunction

    function void write_reg(logic [asc_pkg::CFG_IDX_W-1:0] idx,
                            logic [asc_pkg::CFG_DAT_W-1:0] data);
        case (idx)
            asc_pkg::REG_COEF: coef = data[asc_pkg::COEF_W-1:0];
            asc_pkg::REG_THR:  threshold = data[asc_pkg::THR_W-1:0];
            asc_pkg::REG_RATE: rate = data[asc_pkg::RATE_W-1:0];
            default: ;
        endcase
    endfunction

    static function longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function void note_frame(logic [asc_pkg::N_W-1:0] n,
                             logic signed [asc_pkg::D_W-1:0] d, logic d_known);
        longint        n_l, d_l, sum, avg, lo, hi, want;
        t_frame_result res;
        n_l = longint'(n);
        d_l = longint'(d);
        want = n_l;
        res.corrected = 1'b0;
        frames++;
        if (!d_known) begin
            unknown_diffs++;
        end else if (magnitude(d_l) >= longint'(asc_pkg::NOSYNC_LIM)) begin
            diff_sum = 0;
            warmup_count = 0;
            resyncs++;
        end else begin
            sum = d_l + (longint'(coef) * diff_sum) / 65536;
            if (sum > (longint'(1) <<< 39) - 1) sum = (longint'(1) <<< 39) - 1;
            if (sum < -(longint'(1) <<< 39)) sum = -(longint'(1) <<< 39);
            diff_sum = sum;
            if (warmup_count < avg_frames) begin
                warmup_count++;
            end else begin
                avg = (diff_sum * (65536 - longint'(coef))) / 65536;
                if (magnitude(avg) >= longint'(threshold)) begin
                    lo = n_l * 90 / 100;
                    hi = n_l * 110 / 100;
                    want = n_l + (d_l * longint'(rate)) / 65536;
                    if (want < lo || want > hi) clamps++;
                    if (want < lo) want = lo;
                    if (want > hi) want = hi;
                    res.corrected = 1'b1;
                    corrections++;
                end
            end
        end
        res.wanted = want[asc_pkg::OUT_W-1:0];
        wanted_q.push_back(res);
    endfunction

    function void check_result(logic [asc_pkg::OUT_W-1:0] wanted, logic corrected);
        t_frame_result exp_res;
        results++;
        if (wanted_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word %0d: wanted %0d corrected %b",
                         results, wanted, corrected);
            return;
        end
        exp_res = wanted_q.pop_front();
        if (wanted !== exp_res.wanted || corrected !== exp_res.corrected) begin
            mismatches++;
            if (mismatches <= 10)
                $display("word %0d: wanted exp %0d got %0d, corrected exp %b got %b",
                         results, exp_res.wanted, wanted, exp_res.corrected, corrected);
        end
    endfunction

    function int pending();
        return wanted_q.size();
    endfunction
endclass

module audio_sync_sample_compensator_top_tb;

    localparam int AVG_FRAMES   = asc_pkg::AVG_COUNT_DEF;
    localparam int PHASE_FRAMES = 200;
    localparam int DRAIN_CYCLES = 24;   // covers the longest frame plus the handoff
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_NS     = 2_000_000;

    // index with no register behind it, written once to see it ignored
    localparam logic [asc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // largest difference that still feeds the running sum
    localparam logic signed [asc_pkg::D_W-1:0] D_SYNC_MAX = asc_pkg::NOSYNC_LIM - 1;
    localparam logic [asc_pkg::RATE_W-1:0] RATE_TOP = '1;
    localparam logic [asc_pkg::THR_W-1:0]  THR_TOP  = '1;

    // every input known from time zero
    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic [asc_pkg::N_W-1:0]            i_frame_samples = '0;
    logic signed [asc_pkg::D_W-1:0]     i_clock_diff = '0;
    logic                               i_diff_valid = 1'b0;
    logic                               i_stall = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic [asc_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [asc_pkg::CFG_DAT_W-1:0]      i_cfg_data = '0;
    logic                               o_stall;
    logic                               o_valid;
    logic [asc_pkg::OUT_W-1:0]          o_wanted_samples;
    logic                               o_corrected;
    logic                               o_cfg_ready;

    bit                                 hold_off_req = 1'b0;
    logic signed [asc_pkg::D_W-1:0]     drift = '0;
    int                                 burst_left = 0;
    compensator_scoreboard              sb;

    always #1 i_clk = ~i_clk;

    audio_sync_sample_compensator_top #(
        .AVG_COUNT(AVG_FRAMES)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_frame_samples (i_frame_samples),
        .i_clock_diff    (i_clock_diff),
        .i_diff_valid    (i_diff_valid),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_wanted_samples(o_wanted_samples),
        .o_corrected     (o_corrected),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // offer one frame word from a falling edge and hold it until taken;
    // returns on the falling edge after acceptance with valid still high
    task automatic send_frame(logic [asc_pkg::N_W-1:0] n,
                              logic signed [asc_pkg::D_W-1:0] d, logic d_known);
        i_valid         <= 1'b1;
        i_frame_samples <= n;
        i_clock_diff    <= d;
        i_diff_valid    <= d_known;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        sb.note_frame(n, d, d_known);
        @(negedge i_clk);
    endtask

    // drop valid for a gap whose length the caller gives
    task automatic idle_input(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [asc_pkg::CFG_IDX_W-1:0] idx,
                             logic [asc_pkg::CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic program_regs(logic [asc_pkg::COEF_W-1:0] coef_v,
                                logic [asc_pkg::THR_W-1:0] thr_v,
                                logic [asc_pkg::RATE_W-1:0] rate_v, bit poke_spare);
        write_reg(asc_pkg::REG_COEF, asc_pkg::CFG_DAT_W'(coef_v));
        write_reg(asc_pkg::REG_THR, asc_pkg::CFG_DAT_W'(thr_v));
        write_reg(asc_pkg::REG_RATE, asc_pkg::CFG_DAT_W'(rate_v));
        if (poke_spare)
            write_reg(REG_SPARE, asc_pkg::CFG_DAT_W'($urandom));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // wait for every predicted word, then let the sequencer settle
    task automatic drain_results();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // boundaries first: unknown difference, exactly 10 s either way, just under
    // 10 s, a full warm-up, then clamped high and low, the widest output and an
    // unclamped correction
    task automatic directed_frames();
        int k;
        send_frame(16'hFFFF, 32'sh7FFF_FFFF, 1'b0);
        send_frame(16'h0000, 32'sh8000_0000, 1'b0);
        send_frame(16'd1000, asc_pkg::NOSYNC_LIM, 1'b1);
        send_frame(16'd1000, -asc_pkg::NOSYNC_LIM, 1'b1);
        send_frame(16'd1000, 32'sh8000_0000, 1'b1);
        send_frame(16'hFFFF, D_SYNC_MAX, 1'b1);
        send_frame(16'h0000, -D_SYNC_MAX, 1'b1);
        for (k = 2; k < AVG_FRAMES; k++)
            send_frame(16'(k * 3000 + 1), 32'sd32768, 1'b1);
        send_frame(16'd4096, 32'sd32768, 1'b1);
        send_frame(16'd4096, -32'sd32768, 1'b1);
        send_frame(16'hFFFF, 32'sd32768, 1'b1);
        send_frame(16'd48000, 32'sd100, 1'b1);
        send_frame(16'd48000, -32'sd100, 1'b1);
    endtask

    // mostly in-sync frames riding a slowly changing lag so the averaged
    // difference crosses the threshold; a few unknown and out-of-sync words
    task automatic random_frames(int count);
        int                             k, pick, mag_sel, d_i;
        logic [asc_pkg::N_W-1:0]        n;
        logic signed [asc_pkg::D_W-1:0] d;
        logic                           d_known;
        for (k = 0; k < count; k++) begin
            // sender pacing: gap-free bursts, short gaps, the odd long one
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    burst_left = $urandom_range(20, 60);
                else if (pick < 25)
                    idle_input($urandom_range(1, 3));
                else if (pick < 29)
                    idle_input($urandom_range(15, 50));
            end
            if ($urandom_range(0, 29) == 0) begin
                mag_sel = $urandom_range(0, 3);
                case (mag_sel)
                    0: drift = $urandom_range(0, 255);
                    1: drift = $urandom_range(0, 4095);
                    2: drift = $urandom_range(0, 65535);
                    default: drift = $urandom_range(0, 655359);
                endcase
                if ($urandom_range(0, 1) == 1) drift = -drift;
            end
            pick = $urandom_range(0, 99);
            if (pick < 15)
                n = 16'($urandom_range(0, 2000));
            else if (pick < 20)
                n = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            else
                n = 16'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                d_known = 1'b0;
                d = $urandom;
            end else if (pick < 5) begin
                d_known = 1'b1;
                d = $urandom;
                if (d > -asc_pkg::NOSYNC_LIM && d < asc_pkg::NOSYNC_LIM)
                    d = d ^ 32'h0100_0000;
                if ($urandom_range(0, 7) == 0)
                    d = ($urandom_range(0, 1) == 1) ? asc_pkg::NOSYNC_LIM
                                                    : -asc_pkg::NOSYNC_LIM;
            end else begin
                d_known = 1'b1;
                d_i = int'(drift) + int'($urandom_range(0, 2047)) - 1024;
                if (d_i > int'(D_SYNC_MAX)) d_i = int'(D_SYNC_MAX);
                if (d_i < -int'(D_SYNC_MAX)) d_i = -int'(D_SYNC_MAX);
                d = d_i;
            end
            send_frame(n, d, d_known);
        end
    endtask

    // result side: check every word taken at a rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0)
            sb.check_result(o_wanted_samples, o_corrected);
    end

    // receiver pacing, one stall decision per stretch; a requested hold-off
    // keeps stall up long enough to back the block up into its input
    initial begin : result_pacing
        int pick;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    i_stall <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(negedge i_clk);
                end else if (pick < 90) begin
                    i_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(negedge i_clk);
                end else begin
                    i_stall <= 1'b1;
                    repeat ($urandom_range(10, 60)) @(negedge i_clk);
                end
            end
        end
    end

    initial begin : stimulus
        int phase;
        sb = new(AVG_FRAMES);
        // synchronous reset held from time zero, released on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset register values
        directed_frames();
        random_frames(PHASE_FRAMES - 30);
        idle_input(1);
        drain_results();

        for (phase = 1; phase < 8; phase++) begin
            case (phase)
                // no smoothing, zero threshold, slowest nonzero rate
                1: program_regs(16'd0, 31'd0, 19'd1, 1'b0);
                // heaviest smoothing, fastest rate
                2: program_regs(16'hFFFF, asc_pkg::THR_RST, RATE_TOP, 1'b0);
                // threshold never reached
                3: program_regs(16'($urandom_range(0, 65535)), THR_TOP, 19'd0, 1'b0);
                // corrections with zero rate collapse to the frame size
                4: program_regs(asc_pkg::COEF_RST, 31'd200, 19'd0, 1'b0);
                5: program_regs(16'd32768, 31'($urandom_range(0, 70000)), 19'd44100, 1'b1);
                default: program_regs(16'($urandom_range(0, 65535)),
                                       31'($urandom_range(0, 100000)),
                                       19'($urandom_range(0, 524287)), 1'b0);
            endcase
            if (phase == 2) begin
                random_frames(60);
                hold_off_req = 1'b1;
                random_frames(PHASE_FRAMES - 60);
            end else begin
                random_frames(PHASE_FRAMES);
            end
            idle_input(1);
            drain_results();
        end

        $display("%0d frames: %0d corrected (%0d at the 10%% limit), %0d resyncs, %0d unknown",
                 sb.frames, sb.corrections, sb.clamps, sb.resyncs, sb.unknown_diffs);
        $display("8 register settings incl. zero/top rate and coefficient, %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // run limit
    initial begin : watchdog
        #(LIMIT_NS);
        $display("timeout with %0d words outstanding", sb.pending());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
